/* rtl/core/dec_pkg.sv */
// ----------------------------------------------------------------------------
// dec_pkg
// Types and constants shared by the disc collision pipeline.
// ----------------------------------------------------------------------------
package dec_pkg;

    localparam int CD_W   = 8;
    localparam int POS_W  = 16;
    localparam int VEL_W  = 32;
    localparam int MASS_W = 16;
    localparam int DX_W   = 9;
    localparam int DV_W   = VEL_W + 1;
    localparam int PR_W   = DV_W + DX_W;
    localparam int K_W    = PR_W + 1;
    localparam int KM_W   = PR_W;
    localparam int AM_W   = KM_W + DX_W - 1;
    localparam int MS_W   = MASS_W + 1;
    localparam int N_W    = MS_W;
    localparam int P_W    = AM_W + MS_W;
    localparam int D_W    = MS_W + N_W;
    localparam int Q_W    = 34;
    localparam int BPS    = 2;
    localparam int NL     = 4;
    localparam int NF     = 5;
    localparam int ND     = Q_W / BPS;
    localparam int NST    = NF + ND + 1;
    localparam int SUM_W  = Q_W + 3;

    localparam logic [CD_W-1:0] CD_RESET = 8'd48;

    typedef struct packed {
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic signed [VEL_W-1:0] first_vx;
        logic signed [VEL_W-1:0] first_vy;
        logic signed [VEL_W-1:0] second_vx;
        logic signed [VEL_W-1:0] second_vy;
        logic [MASS_W-1:0]       first_mass;
        logic [MASS_W-1:0]       second_mass;
    } t_in_item;

    typedef struct packed {
        logic                    hit;
        logic signed [VEL_W-1:0] new_first_vx;
        logic signed [VEL_W-1:0] new_first_vy;
        logic signed [VEL_W-1:0] new_second_vx;
        logic signed [VEL_W-1:0] new_second_vy;
    } t_out_item;

    typedef struct packed {
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_tag;

    // lane order: first x, first y, second x, second y
    typedef struct packed {
        t_tag                        tag;
        logic [D_W-1:0]              d;
        logic [NL-1:0][P_W-1:0]      p;
    } t_front_out;

endpackage

/* rtl/core/dec_front.sv */
// ----------------------------------------------------------------------------
// dec_front
// Contact test, approach test and numerator / denominator products.
// ----------------------------------------------------------------------------
module dec_front (
    input  logic                            i_clk,
    input  logic [dec_pkg::NF-1:0]          i_en,
    input  dec_pkg::t_in_item               i_item,
    input  logic [dec_pkg::CD_W-1:0]        i_cd,
    output dec_pkg::t_front_out             o_res
);
    import dec_pkg::*;

    // stage 1
    logic signed [POS_W:0]   c_dx, c_dy;
    logic signed [POS_W+1:0] c_dxe, c_dye, c_w;
    logic                    c_rng;
    logic [MASS_W-1:0]       c_mp, c_mq;
    logic signed [DV_W-1:0]  c_dvx, c_dvy;

    logic                    r_s1_rng;
    logic signed [DX_W-1:0]  r_s1_dx, r_s1_dy;
    logic signed [DV_W-1:0]  r_s1_dvx, r_s1_dvy;
    logic [MASS_W-1:0]       r_s1_mp, r_s1_mq;

    always_comb begin
        c_dx  = $signed({i_item.first_x[POS_W-1], i_item.first_x})
              - $signed({i_item.second_x[POS_W-1], i_item.second_x});
        c_dy  = $signed({i_item.first_y[POS_W-1], i_item.first_y})
              - $signed({i_item.second_y[POS_W-1], i_item.second_y});
        c_dxe = $signed({c_dx[POS_W], c_dx});
        c_dye = $signed({c_dy[POS_W], c_dy});
        c_w   = $signed({{(POS_W+2-CD_W){1'b0}}, i_cd});
        c_rng = (c_dxe <= c_w) && (c_dxe >= -c_w) && (c_dye <= c_w) && (c_dye >= -c_w);
        c_dvx = $signed({i_item.first_vx[VEL_W-1], i_item.first_vx})
              - $signed({i_item.second_vx[VEL_W-1], i_item.second_vx});
        c_dvy = $signed({i_item.first_vy[VEL_W-1], i_item.first_vy})
              - $signed({i_item.second_vy[VEL_W-1], i_item.second_vy});
        // two massless discs count as equal masses
        if (i_item.first_mass == '0 && i_item.second_mass == '0) begin
            c_mp = MASS_W'(1);
            c_mq = MASS_W'(1);
        end else begin
            c_mp = i_item.first_mass;
            c_mq = i_item.second_mass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_rng <= c_rng;
            r_s1_dx  <= c_dx[DX_W-1:0];
            r_s1_dy  <= c_dy[DX_W-1:0];
            r_s1_dvx <= c_dvx;
            r_s1_dvy <= c_dvy;
            r_s1_mp  <= c_mp;
            r_s1_mq  <= c_mq;
        end
    end

    // stage 2
    logic signed [2*DX_W-1:0] c_sqx, c_sqy;
    logic signed [2*DX_W:0]   c_nsum;
    logic signed [PR_W-1:0]   c_px, c_py;

    logic                    r_s2_rng;
    logic signed [DX_W-1:0]  r_s2_dx, r_s2_dy;
    logic [N_W-1:0]          r_s2_n;
    logic signed [PR_W-1:0]  r_s2_px, r_s2_py;
    logic [MS_W-1:0]         r_s2_msum;
    logic [MASS_W-1:0]       r_s2_mp, r_s2_mq;

    always_comb begin
        c_sqx  = r_s1_dx * r_s1_dx;
        c_sqy  = r_s1_dy * r_s1_dy;
        c_nsum = $signed({c_sqx[2*DX_W-1], c_sqx}) + $signed({c_sqy[2*DX_W-1], c_sqy});
        c_px   = r_s1_dvx * r_s1_dx;
        c_py   = r_s1_dvy * r_s1_dy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2_rng  <= r_s1_rng;
            r_s2_dx   <= r_s1_dx;
            r_s2_dy   <= r_s1_dy;
            r_s2_n    <= c_nsum[N_W-1:0];
            r_s2_px   <= c_px;
            r_s2_py   <= c_py;
            r_s2_msum <= {1'b0, r_s1_mp} + {1'b0, r_s1_mq};
            r_s2_mp   <= r_s1_mp;
            r_s2_mq   <= r_s1_mq;
        end
    end

    // stage 3
    logic [2*CD_W-1:0]      c_wsq;
    logic                   c_contact;

    logic                   r_s3_contact;
    logic signed [DX_W-1:0] r_s3_dx, r_s3_dy;
    logic signed [K_W-1:0]  r_s3_k;
    logic [D_W-1:0]         r_s3_d;
    logic [MASS_W-1:0]      r_s3_mp, r_s3_mq;

    always_comb begin
        c_wsq     = i_cd * i_cd;
        c_contact = r_s2_rng && (r_s2_n != '0)
                 && (r_s2_n <= {{(N_W-2*CD_W){1'b0}}, c_wsq});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s3_contact <= c_contact;
            r_s3_dx      <= r_s2_dx;
            r_s3_dy      <= r_s2_dy;
            r_s3_k       <= $signed({r_s2_px[PR_W-1], r_s2_px})
                          + $signed({r_s2_py[PR_W-1], r_s2_py});
            r_s3_d       <= r_s2_msum * r_s2_n;
            r_s3_mp      <= r_s2_mp;
            r_s3_mq      <= r_s2_mq;
        end
    end

    // stage 4: magnitudes of dx*k and dy*k
    logic signed [K_W-1:0]  c_kneg;
    logic [DX_W-1:0]        c_adx, c_ady;

    t_tag                   r_s4_tag;
    logic [AM_W-1:0]        r_s4_ax, r_s4_ay;
    logic [D_W-1:0]         r_s4_d;
    logic [MASS_W-1:0]      r_s4_mp, r_s4_mq;

    always_comb begin
        c_kneg = -r_s3_k;
        c_adx  = r_s3_dx[DX_W-1] ? DX_W'(-r_s3_dx) : r_s3_dx;
        c_ady  = r_s3_dy[DX_W-1] ? DX_W'(-r_s3_dy) : r_s3_dy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s4_tag.hit   <= r_s3_contact && r_s3_k[K_W-1];
            r_s4_tag.neg_x <= r_s3_dx[DX_W-1];
            r_s4_tag.neg_y <= r_s3_dy[DX_W-1];
            r_s4_ax        <= c_adx[DX_W-2:0] * c_kneg[KM_W-1:0];
            r_s4_ay        <= c_ady[DX_W-2:0] * c_kneg[KM_W-1:0];
            r_s4_d         <= r_s3_d;
            r_s4_mp        <= r_s3_mp;
            r_s4_mq        <= r_s3_mq;
        end
    end

    // stage 5: scale by twice the opposite mass
    t_front_out r_s5;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s5.tag  <= r_s4_tag;
            r_s5.d    <= r_s4_d;
            r_s5.p[0] <= r_s4_ax * {r_s4_mq, 1'b0};
            r_s5.p[1] <= r_s4_ay * {r_s4_mq, 1'b0};
            r_s5.p[2] <= r_s4_ax * {r_s4_mp, 1'b0};
            r_s5.p[3] <= r_s4_ay * {r_s4_mp, 1'b0};
        end
    end

    assign o_res = r_s5;

endmodule

/* rtl/core/dec_div.sv */
// ----------------------------------------------------------------------------
// dec_div
// Four-lane pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module dec_div (
    input  logic                                i_clk,
    input  logic [dec_pkg::ND-1:0]              i_en,
    input  dec_pkg::t_front_out                 i_front,
    output dec_pkg::t_tag                       o_tag,
    output logic [dec_pkg::D_W-1:0]             o_d,
    output logic [dec_pkg::NL-1:0]              o_ovf,
    output logic [dec_pkg::NL-1:0][dec_pkg::D_W-1:0] o_rem,
    output logic [dec_pkg::NL-1:0][dec_pkg::Q_W-1:0] o_quo
);
    import dec_pkg::*;

    // one bit of long division; low holds the remaining dividend bits
    // above the quotient bits formed so far
    function automatic logic [D_W+Q_W-1:0] div_step(
        input logic [D_W-1:0] rem,
        input logic [Q_W-1:0] low,
        input logic [D_W-1:0] d
    );
        logic [D_W:0] t;
        logic         qb;
        t  = {rem, low[Q_W-1]};
        qb = (t >= {1'b0, d});
        if (qb) begin
            t = t - {1'b0, d};
        end
        return {t[D_W-1:0], low[Q_W-2:0], qb};
    endfunction

    t_tag                        r_tag [ND];
    logic [D_W-1:0]              r_d   [ND];
    logic [NL-1:0]               r_ovf [ND];
    logic [NL-1:0][D_W-1:0]      r_rem [ND];
    logic [NL-1:0][Q_W-1:0]      r_low [ND];

    logic [NL-1:0][D_W-1:0]      n_rem [ND];
    logic [NL-1:0][Q_W-1:0]      n_low [ND];
    logic [NL-1:0]               c_ovf;

    always_comb begin
        logic [D_W-1:0]       rem;
        logic [Q_W-1:0]       low;
        logic [D_W-1:0]       d;
        logic [D_W+Q_W-1:0]   res;
        for (int l = 0; l < NL; l++) begin
            // quotient at or above 2^Q_W drives the sum into saturation
            c_ovf[l] = {{(D_W-(P_W-Q_W)){1'b0}}, i_front.p[l][P_W-1:Q_W]} >= i_front.d;
        end
        for (int s = 0; s < ND; s++) begin
            for (int l = 0; l < NL; l++) begin
                if (s == 0) begin
                    rem = {{(D_W-(P_W-Q_W)){1'b0}}, i_front.p[l][P_W-1:Q_W]};
                    low = i_front.p[l][Q_W-1:0];
                    d   = i_front.d;
                end else begin
                    rem = r_rem[s-1][l];
                    low = r_low[s-1][l];
                    d   = r_d[s-1];
                end
                for (int b = 0; b < BPS; b++) begin
                    res = div_step(rem, low, d);
                    rem = res[D_W+Q_W-1:Q_W];
                    low = res[Q_W-1:0];
                end
                n_rem[s][l] = rem;
                n_low[s][l] = low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < ND; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                if (s == 0) begin
                    r_tag[s] <= i_front.tag;
                    r_d[s]   <= i_front.d;
                    r_ovf[s] <= c_ovf;
                end else begin
                    r_tag[s] <= r_tag[s-1];
                    r_d[s]   <= r_d[s-1];
                    r_ovf[s] <= r_ovf[s-1];
                end
            end
        end
    end

    assign o_tag = r_tag[ND-1];
    assign o_d   = r_d[ND-1];
    assign o_ovf = r_ovf[ND-1];
    assign o_rem = r_rem[ND-1];
    assign o_quo = r_low[ND-1];

endmodule

/* rtl/core/disc_elastic_collision.sv */
// ----------------------------------------------------------------------------
// disc_elastic_collision
// Elastic collision of a pair of discs with saturated Q16.16 results.
// ----------------------------------------------------------------------------
// Each item carries two discs; the result item holds the hit flag and the
// four new velocities. The block is a 23-stage pipeline: five stages for
// the contact test and the products, seventeen stages of a four-lane divider
// that forms two quotient bits per stage, and one stage for rounding,
// update and saturation, which is also the output register. It takes one
// item per clock when the output side does not stall; a stall holds the
// stages behind it while empty stages ahead still fill. The contact distance
// register resets to 48 and is written only while the pipeline is empty
// and no input item is offered.
module disc_elastic_collision (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dec_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dec_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dec_pkg::CD_W-1:0]    i_cfg_data
);
    import dec_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

    logic [CD_W-1:0]  r_cd;
    logic [NST-1:0]   r_v;
    logic [NST-1:0]   c_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd <= CD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cd <= i_cfg_data;
        end
    end
    // the distance is read at two stages, so it only changes with nothing in flight
    assign o_cfg_ready = (r_v == '0) && !i_in_valid;

    // a stage moves on when it is empty or the stage ahead moves on
    always_comb begin
        c_en[NST-1] = !r_v[NST-1] || i_out_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            c_en[i] = !r_v[i] || c_en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (c_en[i]) begin
                    r_v[i] <= (i == 0) ? i_in_valid : r_v[i-1];
                end
            end
        end
    end

    assign o_in_ready  = c_en[0];
    assign o_out_valid = r_v[NST-1];

    // input velocities ride alongside the arithmetic
    logic [NL-1:0][VEL_W-1:0] r_vel [NST-1];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NST - 1; i++) begin
            if (c_en[i]) begin
                if (i == 0) begin
                    r_vel[i] <= {i_in_item.first_vx, i_in_item.first_vy,
                                 i_in_item.second_vx, i_in_item.second_vy};
                end else begin
                    r_vel[i] <= r_vel[i-1];
                end
            end
        end
    end

    t_front_out                 w_front;
    t_tag                       w_tag;
    logic [D_W-1:0]             w_d;
    logic [NL-1:0]              w_ovf;
    logic [NL-1:0][D_W-1:0]     w_rem;
    logic [NL-1:0][Q_W-1:0]     w_quo;

    dec_front u_front (
        .i_clk  (i_clk),
        .i_en   (c_en[NF-1:0]),
        .i_item (i_in_item),
        .i_cd   (r_cd),
        .o_res  (w_front)
    );

    dec_div u_div (
        .i_clk   (i_clk),
        .i_en    (c_en[NF+ND-1:NF]),
        .i_front (w_front),
        .o_tag   (w_tag),
        .o_d     (w_d),
        .o_ovf   (w_ovf),
        .o_rem   (w_rem),
        .o_quo   (w_quo)
    );

    // rounding, update and saturation; packed lane 3 is first vx
    logic [NL-1:0][VEL_W-1:0]  c_new;

    always_comb begin
        logic                    rnd;
        logic                    sub;
        logic                    neg;
        logic [VEL_W-1:0]        v;
        logic signed [SUM_W-1:0] ve;
        logic signed [SUM_W-1:0] qe;
        logic signed [SUM_W-1:0] sum;
        for (int l = 0; l < NL; l++) begin
            // lane l of the divider maps to packed velocity slot NL-1-l
            v   = r_vel[NST-2][NL-1-l];
            neg = (l % 2 == 0) ? w_tag.neg_x : w_tag.neg_y;
            // first disc moves with the sign of its offset, second against it
            sub = (l < NL / 2) ? neg : !neg;
            rnd = {w_rem[l], 1'b0} >= {1'b0, w_d};
            ve  = $signed({{(SUM_W-VEL_W){v[VEL_W-1]}}, v});
            qe  = $signed({{(SUM_W-Q_W){1'b0}}, w_quo[l]}) + $signed(SUM_W'(rnd));
            sum = sub ? ve - qe : ve + qe;
            if (!w_tag.hit) begin
                c_new[NL-1-l] = v;
            end else if (w_ovf[l]) begin
                c_new[NL-1-l] = sub ? SAT_MIN[VEL_W-1:0] : SAT_MAX[VEL_W-1:0];
            end else if (sum > SAT_MAX) begin
                c_new[NL-1-l] = SAT_MAX[VEL_W-1:0];
            end else if (sum < SAT_MIN) begin
                c_new[NL-1-l] = SAT_MIN[VEL_W-1:0];
            end else begin
                c_new[NL-1-l] = sum[VEL_W-1:0];
            end
        end
    end

    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (c_en[NST-1]) begin
            r_out.hit           <= w_tag.hit;
            r_out.new_first_vx  <= c_new[3];
            r_out.new_first_vy  <= c_new[2];
            r_out.new_second_vx <= c_new[1];
            r_out.new_second_vy <= c_new[0];
        end
    end

    assign o_out_item = r_out;

endmodule

/* test/tb_disc_elastic_collision.sv */
// ----------------------------------------------------------------------------
// tb_disc_elastic_collision
// Self-checking bench for the disc collision pipeline: directed and random
// disc pairs under random idling and back-pressure, several contact
// distances, every result checked against an in-bench collision predictor.
// ----------------------------------------------------------------------------
module tb_disc_elastic_collision;
    timeunit 1ns;
    timeprecision 1ps;

    import dec_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 20000;

    // collision predictor and store of expected velocity sets
    class collision_board;
        t_out_item     pending[$];
        int            n_errors;
        int            n_checked;
        int            n_hits;
        int unsigned   contact_dist;

        function new();
            n_errors     = 0;
            n_checked    = 0;
            n_hits       = 0;
            contact_dist = CD_RESET;
        endfunction

        // round(|p| * m2 / d), nearest, ties away from zero, sign of p
        function automatic longint scaled_share(longint p, longint m2, longint d);
            logic [127:0] prod;
            logic [127:0] q;
            logic [127:0] r;
            longint       mag;
            mag  = (p < 0) ? -p : p;
            prod = 128'(mag) * 128'(m2);
            q    = prod / 128'(d);
            r    = prod % 128'(d);
            if (r >= 128'(d) - r)
                q = q + 1;
            return (p < 0) ? -longint'(q) : longint'(q);
        endfunction

        function automatic longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function void note_item(t_in_item it);
            t_out_item e;
            longint dx, dy, n, k, w, mp, mq, d;
            longint fvx, fvy, svx, svy;
            fvx = it.first_vx;
            fvy = it.first_vy;
            svx = it.second_vx;
            svy = it.second_vy;
            dx  = longint'(it.first_x) - longint'(it.second_x);
            dy  = longint'(it.first_y) - longint'(it.second_y);
            w   = contact_dist;
            mp  = it.first_mass;
            mq  = it.second_mass;
            e.hit           = 1'b0;
            e.new_first_vx  = it.first_vx;
            e.new_first_vy  = it.first_vy;
            e.new_second_vx = it.second_vx;
            e.new_second_vy = it.second_vy;
            if (dx >= -w && dx <= w && dy >= -w && dy <= w) begin
                n = dx * dx + dy * dy;
                k = (fvx - svx) * dx + (fvy - svy) * dy;
                if (n != 0 && n <= w * w && k < 0) begin
                    if (mp == 0 && mq == 0) begin
                        mp = 1;
                        mq = 1;
                    end
                    d = (mp + mq) * n;
                    e.hit           = 1'b1;
                    e.new_first_vx  = 32'(clamp32(fvx - scaled_share(dx * k, 2 * mq, d)));
                    e.new_first_vy  = 32'(clamp32(fvy - scaled_share(dy * k, 2 * mq, d)));
                    e.new_second_vx = 32'(clamp32(svx + scaled_share(dx * k, 2 * mp, d)));
                    e.new_second_vy = 32'(clamp32(svy + scaled_share(dy * k, 2 * mp, d)));
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result item, exp none, got %h", $realtime, got);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (e.hit)
                n_hits++;
            if (got.hit !== e.hit) begin
                $display("%0t: hit exp %0b got %0b", $realtime, e.hit, got.hit);
                n_errors++;
            end
            if (got.new_first_vx !== e.new_first_vx) begin
                $display("%0t: new_first_vx exp %0d got %0d", $realtime,
                         e.new_first_vx, got.new_first_vx);
                n_errors++;
            end
            if (got.new_first_vy !== e.new_first_vy) begin
                $display("%0t: new_first_vy exp %0d got %0d", $realtime,
                         e.new_first_vy, got.new_first_vy);
                n_errors++;
            end
            if (got.new_second_vx !== e.new_second_vx) begin
                $display("%0t: new_second_vx exp %0d got %0d", $realtime,
                         e.new_second_vx, got.new_second_vx);
                n_errors++;
            end
            if (got.new_second_vy !== e.new_second_vy) begin
                $display("%0t: new_second_vy exp %0d got %0d", $realtime,
                         e.new_second_vy, got.new_second_vy);
                n_errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    t_in_item           in_item;
    logic               out_valid;
    logic               out_ready;
    t_out_item          out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CD_W-1:0]    cfg_data;

    collision_board     board;
    bit                 rx_hold_req;
    bit                 rx_random;
    int                 idle_cycles;
    int                 n_items;
    int                 n_settings;

    disc_elastic_collision u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial begin
        board       = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        rx_hold_req = 1'b0;
        rx_random   = 1'b1;
        idle_cycles = 0;
        n_items     = 0;
        n_settings  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog on cycles with no item moving
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // check each accepted result; the receiver below makes random stalls, one long hold-off on request
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_item);
    end

    initial begin
        int wait_n;
        @(posedge rst_n);
        forever begin
            if (rx_hold_req) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            wait_n = rx_random ? $urandom_range(0, 13) : 0;
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_item(t_in_item it, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(it);
        n_items++;
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_contact(logic [CD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.contact_dist = value;
        n_settings++;
    endtask

    function automatic t_in_item make_item(int w, bit in_range);
        t_in_item it;
        int       span;
        it = '0;
        span = (w > 0) ? w : 1;
        it.first_x  = 16'($urandom);
        it.first_y  = 16'($urandom);
        if (in_range) begin
            it.second_x = it.first_x + 16'(int'($urandom_range(0, 2 * span)) - span);
            it.second_y = it.first_y + 16'(int'($urandom_range(0, 2 * span)) - span);
        end else begin
            it.second_x = 16'($urandom);
            it.second_y = 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0: begin
                it.first_vx  = $urandom;
                it.first_vy  = $urandom;
                it.second_vx = $urandom;
                it.second_vy = $urandom;
            end
            default: begin
                it.first_vx  = 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
                it.first_vy  = 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
                it.second_vx = 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
                it.second_vy = 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            end
        endcase
        case ($urandom_range(0, 9))
            0: begin
                it.first_mass  = 16'd0;
                it.second_mass = 16'd0;
            end
            1: begin
                it.first_mass  = 16'd0;
                it.second_mass = 16'($urandom);
            end
            2: begin
                it.first_mass  = 16'hFFFF;
                it.second_mass = 16'($urandom_range(1, 4));
            end
            default: begin
                it.first_mass  = 16'($urandom);
                it.second_mass = 16'($urandom);
            end
        endcase
        return it;
    endfunction

    function automatic t_in_item pair(int fx, int fy, int sx, int sy,
                                      int fvx, int fvy, int svx, int svy,
                                      int mp, int mq);
        t_in_item it;
        it.first_x     = 16'(fx);
        it.first_y     = 16'(fy);
        it.second_x    = 16'(sx);
        it.second_y    = 16'(sy);
        it.first_vx    = 32'(fvx);
        it.first_vy    = 32'(fvy);
        it.second_vx   = 32'(svx);
        it.second_vy   = 32'(svy);
        it.first_mass  = 16'(mp);
        it.second_mass = 16'(mq);
        return it;
    endfunction

    initial begin
        t_in_item       it;
        int             w;
        int unsigned    cd_list[6];
        @(posedge rst_n);
        @(posedge clk);

        // directed: reset distance, head-on, glancing, separating, edge cases
        send_item(pair(0, 0, 10, 0, 32'h0001_0000, 0, -32'sh0001_0000, 0, 256, 256), 0);
        send_item(pair(0, 0, 48, 0, 32'h0001_0000, 0, 0, 0, 256, 256), 0);
        send_item(pair(0, 0, 49, 0, 32'h0001_0000, 0, 0, 0, 256, 256), 0);
        send_item(pair(0, 0, 34, 34, 32'h0001_0000, 32'h0001_0000, 0, 0, 256, 256), 0);
        send_item(pair(0, 0, 33, 33, 32'h0001_0000, 32'h0001_0000, 0, 0, 256, 256), 0);
        send_item(pair(5, 5, 5, 5, 32'h0001_0000, 0, 0, 0, 256, 256), 0);
        send_item(pair(0, 0, 10, 0, -32'sh0001_0000, 0, 32'h0001_0000, 0, 256, 256), 0);
        send_item(pair(0, 0, 10, 0, 0, 32'h0001_0000, 0, 0, 256, 256), 0);
        send_item(pair(0, 0, 3, 4, 32'h0003_0000, 32'h0001_0000, 0, -32'sh0002_0000, 0, 0), 0);
        send_item(pair(0, 0, 3, 4, 32'h0003_0000, 32'h0001_0000, 0, 0, 0, 512), 0);
        send_item(pair(0, 0, 1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 65535, 1), 0);
        send_item(pair(0, 0, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 1, 65535), 0);
        send_item(pair(32767, -32768, -32768, 32767, 1, 1, 1, 1, 65535, 65535), 0);
        send_item(pair(-32768, 32767, -32768 + 20, 32767 - 30, 32'h0100_0000, 0, 0,
                       32'h8000_0000, 300, 7), 0);
        send_item(pair(32767, 32767, 32767 - 7, 32767, 32'h0000_0001, 0,
                       32'hFFFF_FFFF, 0, 1, 1), 0);
        send_item(pair(0, 0, -48, 0, -32'sh0002_0000, 0, 0, 0, 1000, 3), 0);
        drain_all();

        // random phases across contact distances, extremes included
        cd_list[0] = 1;
        cd_list[1] = 255;
        cd_list[2] = 0;
        cd_list[3] = $urandom_range(2, 254);
        cd_list[4] = 255;
        cd_list[5] = CD_RESET;
        foreach (cd_list[i]) begin
            write_contact(CD_W'(cd_list[i]));
            w = cd_list[i];
            for (int j = 0; j < 90; j++) begin
                it = make_item(w, $urandom_range(0, 9) < 8);
                if (i == 1 && j == 40)
                    rx_hold_req = 1'b1;
                // some bursts without gaps on either side
                if (i == 3 && j < 30) begin
                    rx_random = 1'b0;
                    send_item(it, 0);
                end else begin
                    rx_random = 1'b1;
                    send_item(it, $urandom_range(0, 13));
                end
                if (i == 4 && j == 45) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (board.pending.size() != 0)
                        @(posedge clk);
                end
            end
            drain_all();
        end

        $display("covered %0d items, %0d results with %0d hits, %0d distance settings",
                 n_items, board.n_checked, board.n_hits, n_settings);
        if (board.n_errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
